// ===== rtl/core/eac_pkg.sv =====
// Package for the expiring access cache: field widths, item kind codes,
// lookup status codes and the compare unit result type. No dependencies.
`timescale 1ns / 1ps

package eac_pkg;

  // Fixed field widths of the input and result words.
  localparam int KIND_W = 3;
  localparam int KEY_W  = 56;
  localparam int TIME_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  // Largest count the result fields can show.
  localparam int CNT_MAX = 31;

  // Default configuration of the table.
  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 56;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_LOOKUP    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUT       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INVAL     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UPDATE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PURGE_ALL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PURGE_EXP = 3'd5;

  // Lookup status codes.
  localparam logic [STAT_W-1:0] STAT_MISS    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_HIT     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EXPIRED = 2'd2;

  // Result of the shared compare unit for one table entry.
  typedef struct packed {
    logic key_eq;      // stored key equals the item key
    logic exp_zero;    // expiry is zero: entry never expires
    logic now_before;  // current time is before the expiry
  } cmp_res_t;

endpackage

// ===== rtl/core/eac_if.sv =====
// Handshake channels of the expiring access cache: the request word and the
// result word, each with valid, ready and payload. Depends on eac_pkg.
`timescale 1ns / 1ps

// Request channel.
interface eac_in_if import eac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  card_key;
  logic [TIME_W-1:0] ttl_seconds;
  logic [TIME_W-1:0] current_time;

  modport source(output valid, kind, card_key, ttl_seconds, current_time, input ready);
  modport sink(input valid, kind, card_key, ttl_seconds, current_time, output ready);
endinterface

// Result channel.
interface eac_out_if import eac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  removed_count;
  logic [CNT_W-1:0]  occupancy;
  logic              cleared_on_full;

  modport source(output valid, status, removed_count, occupancy, cleared_on_full,
                 input ready);
  modport sink(input valid, status, removed_count, occupancy, cleared_on_full,
               output ready);
endinterface

// ===== rtl/core/eac_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`timescale 1ns / 1ps

module eac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/eac_cmp.sv =====
// Shared compare unit of the expiring access cache: checks one table entry
// against the item key and the current time. Depends on eac_pkg.
`timescale 1ns / 1ps

module eac_cmp import eac_pkg::*; #(
  parameter int KW = KEY_BITS_DEF
) (
  input  logic [KW-1:0]     entry_key,
  input  logic [KW-1:0]     item_key,
  input  logic [TIME_W-1:0] entry_expiry,
  input  logic [TIME_W-1:0] now,
  output cmp_res_t          res
);

  // Key equality, never-expires test and the expiry time compare.
  always_comb begin
    res.key_eq     = (entry_key == item_key);
    res.exp_zero   = (entry_expiry == '0);
    res.now_before = (now < entry_expiry);
  end

endmodule

// ===== rtl/core/expiring_access_cache.sv =====
// Expiring access cache: a table of card keys with expiry times, scanned one
// entry per cycle through a single compare unit under a small sequencer.
// Lookup, put, invalidate, update-all and purge-expired pass through the scan,
// drain, commit and done states; purge-all and unknown kinds go from idle
// straight to commit and done. One request at a time: the next request is taken
// only back in idle, and a stalled result word holds the block in its last step.
// Reset (rst_n low, synchronous) empties the table at once.
`timescale 1ns / 1ps

module expiring_access_cache import eac_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  eac_in_if.sink    in_req,
  eac_out_if.source out_rsp
);

  // Derived widths.
  localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int SAT_W = (OCC_W > CNT_W) ? OCC_W : CNT_W;
  localparam int RAM_W = KW + TIME_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               ev_vld_r, ev_vld_nxt;
  logic [IDX_W-1:0]   ev_idx_r, ev_idx_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;

  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [KW-1:0]      key_r, key_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [TIME_W-1:0]  newexp_r, newexp_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_r, free_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [OCC_W-1:0]   removed_r, removed_nxt;
  logic               cleared_r, cleared_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [CNT_W-1:0]   out_removed_r, out_removed_nxt;
  logic [CNT_W-1:0]   out_occ_r, out_occ_nxt;
  logic               out_cleared_r, out_cleared_nxt;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [RAM_W-1:0]   wr_data;
  logic [RAM_W-1:0]   rd_data;
  logic [KW-1:0]      rd_key;
  logic [TIME_W-1:0]  rd_exp;
  cmp_res_t           cmp;

  // Saturate a table count to the width of the result fields.
  function automatic logic [CNT_W-1:0] sat_cnt(input logic [OCC_W-1:0] cnt);
    logic [SAT_W-1:0] ext;
    ext = SAT_W'(cnt);
    if (ext > SAT_W'(CNT_MAX)) begin
      return CNT_W'(CNT_MAX);
    end
    return CNT_W'(ext);
  endfunction

  // Key and expiry storage, one word per entry.
  eac_ram #(
    .WIDTH(RAM_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign rd_key = rd_data[RAM_W-1:TIME_W];
  assign rd_exp = rd_data[TIME_W-1:0];

  // Compare unit shared by every scan step.
  eac_cmp #(
    .KW(KW)
  ) u_cmp (
    .entry_key    (rd_key),
    .item_key     (key_r),
    .entry_expiry (rd_exp),
    .now          (now_r),
    .res          (cmp)
  );

  assign in_req.ready = (state_r == S_IDLE);

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.removed_count   = out_removed_r;
  assign out_rsp.occupancy       = out_occ_r;
  assign out_rsp.cleared_on_full = out_cleared_r;

  // Sequencer, scan evaluation and commit.
  always_comb begin
    logic ent_vld;
    logic match;

    state_nxt       = state_r;
    idx_nxt         = idx_r;
    ev_vld_nxt      = 1'b0;
    ev_idx_nxt      = idx_r;
    valid_nxt       = valid_r;
    occ_nxt         = occ_r;
    kind_nxt        = kind_r;
    key_nxt         = key_r;
    now_nxt         = now_r;
    newexp_nxt      = newexp_r;
    found_nxt       = found_r;
    slot_nxt        = slot_r;
    free_found_nxt  = free_found_r;
    free_nxt        = free_r;
    status_nxt      = status_r;
    removed_nxt     = removed_r;
    cleared_nxt     = cleared_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_occ_nxt     = out_occ_r;
    out_cleared_nxt = out_cleared_r;
    wr_en           = 1'b0;
    wr_addr         = ev_idx_r;
    wr_data         = {rd_key, newexp_r};

    ent_vld = valid_r[ev_idx_r];
    match   = ent_vld && cmp.key_eq;

    // The result word leaves when the sink takes it.
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Evaluate the entry whose data the RAM returned this cycle.
    if (ev_vld_r) begin
      case (kind_r)
        KIND_LOOKUP: begin
          if (match && !found_r) begin
            found_nxt  = 1'b1;
            status_nxt = (cmp.exp_zero || cmp.now_before) ? STAT_HIT : STAT_EXPIRED;
          end
        end
        KIND_PUT: begin
          if (match && !found_r) begin
            found_nxt = 1'b1;
            slot_nxt  = ev_idx_r;
          end
          if (!ent_vld && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_nxt       = ev_idx_r;
          end
        end
        KIND_INVAL: begin
          if (match && !found_r) begin
            found_nxt           = 1'b1;
            valid_nxt[ev_idx_r] = 1'b0;
            removed_nxt         = OCC_W'(1);
            occ_nxt             = occ_r - OCC_W'(1);
          end
        end
        KIND_UPDATE: begin
          if (ent_vld && !cmp.exp_zero) begin
            wr_en = 1'b1;
          end
        end
        KIND_PURGE_EXP: begin
          if (ent_vld && !cmp.exp_zero && !cmp.now_before) begin
            valid_nxt[ev_idx_r] = 1'b0;
            removed_nxt         = removed_r + OCC_W'(1);
            occ_nxt             = occ_r - OCC_W'(1);
          end
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          kind_nxt       = in_req.kind;
          key_nxt        = in_req.card_key[KW-1:0];
          now_nxt        = in_req.current_time;
          newexp_nxt     = in_req.current_time + in_req.ttl_seconds;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          status_nxt     = STAT_MISS;
          removed_nxt    = '0;
          cleared_nxt    = 1'b0;
          idx_nxt        = '0;
          if (in_req.kind == KIND_PURGE_ALL || in_req.kind > KIND_PURGE_EXP) begin
            state_nxt = S_COMMIT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Issue one entry read per cycle.
        ev_vld_nxt = 1'b1;
        ev_idx_nxt = idx_r;
        if (idx_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        // Table-wide actions: the put after its scan, and purge-all.
        if (kind_r == KIND_PUT) begin
          wr_en   = 1'b1;
          wr_data = {key_r, newexp_r};
          if (found_r) begin
            wr_addr = slot_r;
          end else if (occ_r == OCC_W'(ENTRIES)) begin
            valid_nxt    = '0;
            valid_nxt[0] = 1'b1;
            removed_nxt  = occ_r;
            cleared_nxt  = 1'b1;
            occ_nxt      = OCC_W'(1);
            wr_addr      = '0;
          end else begin
            wr_addr           = free_r;
            valid_nxt[free_r] = 1'b1;
            occ_nxt           = occ_r + OCC_W'(1);
          end
        end else if (kind_r == KIND_PURGE_ALL) begin
          valid_nxt   = '0;
          removed_nxt = occ_r;
          occ_nxt     = '0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hand the result word to the output register once it is free.
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_removed_nxt = sat_cnt(removed_r);
          out_occ_nxt     = sat_cnt(occ_r);
          out_cleared_nxt = cleared_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ev_vld_r    <= 1'b0;
      valid_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ev_vld_r    <= ev_vld_nxt;
      valid_r     <= valid_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    ev_idx_r      <= ev_idx_nxt;
    kind_r        <= kind_nxt;
    key_r         <= key_nxt;
    now_r         <= now_nxt;
    newexp_r      <= newexp_nxt;
    found_r       <= found_nxt;
    slot_r        <= slot_nxt;
    free_found_r  <= free_found_nxt;
    free_r        <= free_nxt;
    status_r      <= status_nxt;
    removed_r     <= removed_nxt;
    cleared_r     <= cleared_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_occ_r     <= out_occ_nxt;
    out_cleared_r <= out_cleared_nxt;
  end

endmodule

// ===== tb/tb_expiring_access_cache.sv =====
// Self-checking testbench for the expiring access cache: a directed table, then random
// traffic, checked against the typed results of the table or an in-bench predictor.
// Depends on eac_pkg, eac_if.sv and expiring_access_cache.
`timescale 1ns / 1ps

module tb_expiring_access_cache;
  import eac_pkg::*;

  localparam int ENTRIES    = ENTRIES_DEF;
  localparam int HALF_CLK   = 10;
  localparam int RST_CYCLES = 7;
  localparam int TAIL       = ENTRIES + 3 + 20;
  localparam int LIMIT      = 600000;
  localparam int RAND_ITEMS = 1250;
  localparam int KEY_POOL   = 20;

  // Kind codes the block does not implement.
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  localparam logic [KEY_W-1:0]  KEY_ONES  = '1;
  localparam logic [TIME_W-1:0] TIME_ONES = '1;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [TIME_W-1:0] secs_t;

  // One result word.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  removed_count;
    logic [CNT_W-1:0]  occupancy;
    logic              cleared_on_full;
  } reply_t;

  // One row of the directed table; reps repeats the row with the key counting up.
  typedef struct {
    logic [KIND_W-1:0] kind;
    key_t              key;
    secs_t             ttl;
    secs_t             now;
    int                reps;
    bit                typed;
    reply_t            want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  eac_in_if  rq ();
  eac_out_if rs ();

  expiring_access_cache uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (rq),
    .out_rsp(rs)
  );

  always #(HALF_CLK) clk = ~clk;

  // Predicted table contents.
  bit    tab_valid  [ENTRIES];
  key_t  tab_key    [ENTRIES];
  secs_t tab_expiry [ENTRIES];

  reply_t   pending_replies[$];
  dir_row_t dir_rows[$];
  key_t     key_pool[KEY_POOL];

  int snd_idle = 27;
  int rcv_idle = 59;
  int mismatches = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int hit_count = 0;
  int expired_count = 0;
  int clear_count = 0;
  secs_t wall = '0;

  function automatic int live_entries();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (tab_valid[i]) n++;
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] clip_count(int n);
    return (n > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(n);
  endfunction

  // Apply one request word to the predicted table and return its result word.
  function automatic reply_t next_reply(logic [KIND_W-1:0] kind, key_t key,
                                        secs_t ttl, secs_t now);
    reply_t r;
    int     slot;
    int     n;
    int     removed;
    secs_t  new_exp;
    r = '0;
    slot = -1;
    removed = 0;
    new_exp = now + ttl;
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && tab_valid[i] && tab_key[i] == key) slot = i;
    case (kind)
      KIND_LOOKUP: begin
        if (slot >= 0)
          r.status = (tab_expiry[slot] == '0 || now < tab_expiry[slot]) ?
                     STAT_HIT : STAT_EXPIRED;
      end
      KIND_PUT: begin
        if (slot < 0) begin
          n = live_entries();
          // A new key on a full table wipes everything first.
          if (n >= ENTRIES) begin
            for (int i = 0; i < ENTRIES; i++) tab_valid[i] = 1'b0;
            removed = n;
            r.cleared_on_full = 1'b1;
          end
          for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !tab_valid[i]) slot = i;
        end
        tab_valid[slot]  = 1'b1;
        tab_key[slot]    = key;
        tab_expiry[slot] = new_exp;
      end
      KIND_INVAL: begin
        if (slot >= 0) begin
          tab_valid[slot] = 1'b0;
          removed = 1;
        end
      end
      KIND_UPDATE: begin
        for (int i = 0; i < ENTRIES; i++)
          if (tab_valid[i] && tab_expiry[i] != '0) tab_expiry[i] = new_exp;
      end
      KIND_PURGE_ALL: begin
        removed = live_entries();
        for (int i = 0; i < ENTRIES; i++) tab_valid[i] = 1'b0;
      end
      KIND_PURGE_EXP: begin
        for (int i = 0; i < ENTRIES; i++)
          if (tab_valid[i] && tab_expiry[i] != '0 && now >= tab_expiry[i]) begin
            tab_valid[i] = 1'b0;
            removed++;
          end
      end
      default: begin
      end
    endcase
    r.removed_count = clip_count(removed);
    r.occupancy     = clip_count(live_entries());
    return r;
  endfunction

  function automatic key_t rand_key();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[KEY_W-1:0];
  endfunction

  // Offer one request word from a falling edge until it is taken, then
  // record its expected result. Returns at a falling edge.
  task automatic send_word(logic [KIND_W-1:0] kind, key_t key, secs_t ttl, secs_t now,
                           bit typed, reply_t want);
    reply_t p;
    while ($urandom_range(99) < snd_idle) begin
      rq.valid = 1'b0;
      @(negedge clk);
    end
    rq.valid        = 1'b1;
    rq.kind         = kind;
    rq.card_key     = key;
    rq.ttl_seconds  = ttl;
    rq.current_time = now;
    do @(posedge clk); while (!(rq.valid && rq.ready));
    p = next_reply(kind, key, ttl, now);
    pending_replies.insert(pending_replies.size(), typed ? want : p);
    words_sent++;
    if (p.status == STAT_HIT) hit_count++;
    if (p.status == STAT_EXPIRED) expired_count++;
    if (p.cleared_on_full) clear_count++;
    @(negedge clk);
  endtask

  // Hold the request channel quiet until every result has come back.
  task automatic drain_replies();
    rq.valid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(logic [KIND_W-1:0] kind, key_t key, secs_t ttl, secs_t now,
                         int reps, bit typed, logic [STAT_W-1:0] st, int rem, int occ,
                         bit clr);
    dir_row_t d;
    d.kind  = kind;
    d.key   = key;
    d.ttl   = ttl;
    d.now   = now;
    d.reps  = reps;
    d.typed = typed;
    d.want  = '{status: st, removed_count: CNT_W'(rem), occupancy: CNT_W'(occ),
                cleared_on_full: clr};
    dir_rows.insert(dir_rows.size(), d);
  endtask

  // Draw one random request word and send it; returns 1 if its kind is a real one.
  task automatic send_random(output bit counted);
    int                w;
    int                t;
    logic [KIND_W-1:0] kind;
    key_t              key;
    secs_t             ttl;
    secs_t             now;
    w = $urandom_range(99);
    if (w < 34)      kind = KIND_LOOKUP;
    else if (w < 62) kind = KIND_PUT;
    else if (w < 72) kind = KIND_INVAL;
    else if (w < 76) kind = KIND_UPDATE;
    else if (w < 79) kind = KIND_PURGE_ALL;
    else if (w < 92) kind = KIND_PURGE_EXP;
    else             kind = ($urandom_range(1) != 0) ? KIND_SPARE_7 : KIND_SPARE_6;
    key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL - 1)] : rand_key();
    t = $urandom_range(9);
    if (t == 0)      ttl = '0;
    else if (t == 1) ttl = $urandom();
    else             ttl = secs_t'($urandom_range(60, 1));
    // Time mostly creeps forward, with the odd jump anywhere.
    if ($urandom_range(99) < 4) wall = $urandom();
    else wall = wall + secs_t'($urandom_range(8));
    now = ($urandom_range(9) == 0) ? wall - secs_t'($urandom_range(5)) : wall;
    counted = (kind != KIND_SPARE_6 && kind != KIND_SPARE_7);
    send_word(kind, key, ttl, now, 1'b0, '0);
  endtask

  // Result side: stall at random and accept words at the rising edge.
  always @(negedge clk) begin
    rs.ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && rs.valid && rs.ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result word: status %0d removed_count %0d occupancy %0d",
               rs.status, rs.removed_count, rs.occupancy);
        mismatches++;
      end else begin
        exp_r = pending_replies.pop_front();
        words_checked++;
        if (rs.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, rs.status);
          mismatches++;
        end
        if (rs.removed_count !== exp_r.removed_count) begin
          $error("removed_count: expected %0d, actual %0d",
                 exp_r.removed_count, rs.removed_count);
          mismatches++;
        end
        if (rs.occupancy !== exp_r.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", exp_r.occupancy, rs.occupancy);
          mismatches++;
        end
        if (rs.cleared_on_full !== exp_r.cleared_on_full) begin
          $error("cleared_on_full: expected %0d, actual %0d",
                 exp_r.cleared_on_full, rs.cleared_on_full);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Main sequence: reset, directed table, three random phases, drain.
  initial begin
    bit counted;
    int real_words;
    rq.valid        = 1'b0;
    rq.kind         = KIND_LOOKUP;
    rq.card_key     = '0;
    rq.ttl_seconds  = '0;
    rq.current_time = '0;
    rs.ready        = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      tab_valid[i]  = 1'b0;
      tab_key[i]    = '0;
      tab_expiry[i] = '0;
    end

    // Empty table, spare kinds and purge of nothing.
    add_row(KIND_LOOKUP,    '0,       '0,        '0,        1, 1, STAT_MISS, 0, 0, 0);
    add_row(KIND_SPARE_6,   '0,       '0,        '0,        1, 1, STAT_MISS, 0, 0, 0);
    add_row(KIND_SPARE_7,   KEY_ONES, TIME_ONES, TIME_ONES, 1, 1, STAT_MISS, 0, 0, 0);
    add_row(KIND_PURGE_ALL, '0,       '0,        '0,        1, 1, STAT_MISS, 0, 0, 0);
    // A zero expiry never runs out, even at the top of the clock.
    add_row(KIND_PUT,       KEY_ONES, '0,        '0,        1, 1, STAT_MISS, 0, 1, 0);
    add_row(KIND_LOOKUP,    KEY_ONES, '0,        TIME_ONES, 1, 1, STAT_HIT,  0, 1, 0);
    // Hit just before the expiry, expired exactly at it.
    add_row(KIND_PUT,       56'd0,    32'd10,    32'd100,   1, 1, STAT_MISS, 0, 2, 0);
    add_row(KIND_LOOKUP,    56'd0,    '0,        32'd109,   1, 1, STAT_HIT,  0, 2, 0);
    add_row(KIND_LOOKUP,    56'd0,    '0,        32'd110,   1, 1, STAT_EXPIRED, 0, 2, 0);
    // The sum wraps to zero, so this entry never expires.
    add_row(KIND_PUT,       56'd1,    32'd1,     TIME_ONES, 1, 1, STAT_MISS, 0, 3, 0);
    add_row(KIND_LOOKUP,    56'd1,    '0,        TIME_ONES, 1, 1, STAT_HIT,  0, 3, 0);
    // Overwrite of a present key, then invalidates of an absent and a present key.
    add_row(KIND_PUT,       56'd0,    32'd5,     32'd200,   1, 1, STAT_MISS, 0, 3, 0);
    add_row(KIND_INVAL,     56'd5,    '0,        '0,        1, 1, STAT_MISS, 0, 3, 0);
    add_row(KIND_INVAL,     56'd1,    '0,        '0,        1, 1, STAT_MISS, 1, 2, 0);
    add_row(KIND_UPDATE,    '0,       32'd7,     32'd300,   1, 0, STAT_MISS, 0, 0, 0);
    add_row(KIND_PURGE_EXP, '0,       '0,        32'd307,   1, 0, STAT_MISS, 0, 0, 0);
    add_row(KIND_PURGE_ALL, '0,       '0,        '0,        1, 0, STAT_MISS, 0, 0, 0);
    // Fill the table, then a new key clears it before going in.
    add_row(KIND_PUT,       56'h100000, 32'd1000, '0,       ENTRIES, 0, STAT_MISS, 0, 0, 0);
    add_row(KIND_PUT,       56'hABC,  '0,        '0,        1, 1, STAT_MISS, ENTRIES, 1, 1);
    add_row(KIND_UPDATE,    '0,       TIME_ONES, TIME_ONES, 1, 0, STAT_MISS, 0, 0, 0);
    // Update-all whose new expiry wraps to zero.
    add_row(KIND_PUT,       56'd5,    32'd3,     32'd50,    1, 0, STAT_MISS, 0, 0, 0);
    add_row(KIND_UPDATE,    '0,       TIME_ONES, 32'd1,     1, 0, STAT_MISS, 0, 0, 0);
    add_row(KIND_PURGE_EXP, '0,       '0,        TIME_ONES, 1, 0, STAT_MISS, 0, 0, 0);
    add_row(KIND_LOOKUP,    56'd5,    '0,        TIME_ONES, 1, 0, STAT_MISS, 0, 0, 0);

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[r])
      for (int k = 0; k < dir_rows[r].reps; k++)
        send_word(dir_rows[r].kind, dir_rows[r].key + key_t'(k), dir_rows[r].ttl,
                  dir_rows[r].now, dir_rows[r].typed, dir_rows[r].want);

    // Random phases: receiver-heavy idling, sender-heavy idling, then none.
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 27 : (ph == 1) ? 59 : 0;
      rcv_idle = (ph == 0) ? 59 : (ph == 1) ? 27 : 0;
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = rand_key();
      real_words = 0;
      while (real_words < RAND_ITEMS / 3) begin
        send_random(counted);
        if (counted) real_words++;
      end
      drain_replies();
    end

    rq.valid = 1'b0;
    repeat (TAIL) @(posedge clk);

    $display("Sent %0d request words, checked %0d results: %0d hits, %0d expired,",
             words_sent, words_checked, hit_count, expired_count);
    $display("%0d full-table clears, over three idling phases.", clear_count);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== expiring_access_cache.f =====
rtl/core/eac_pkg.sv
rtl/core/eac_if.sv
rtl/core/eac_ram.sv
rtl/core/eac_cmp.sv
rtl/core/expiring_access_cache.sv
tb/tb_expiring_access_cache.sv
